### hw/rtl/scs_pkg.sv
// Shared constants, types and coefficient functions for the sine/cosine series block.
package scs_pkg;

   localparam int DEF_TERMS           = 10;
   localparam int DEF_ANGLE_FRAC_BITS = 24;
   localparam int DEF_OUT_FRAC_BITS   = 30;

   localparam int ANGLE_WIDTH = 32;
   localparam int OUT_WIDTH   = 32;
   localparam int WORK_WIDTH  = 64;
   localparam int WORK_FRAC   = 60;

   // Angle constants with 59 fraction bits, truncated.
   localparam logic [63:0] TWO_PI_Q59  = 64'h3243F6A8885A308D;
   localparam logic [63:0] PI_Q59      = 64'h1921FB54442D1846;
   localparam logic [63:0] HALF_PI_Q59 = 64'h0C90FDAA22168C23;

   // Quarter-turn fold applied ahead of the series.
   typedef enum logic [1:0] {
      FOLD_NONE,
      FOLD_POS,
      FOLD_NEG
   } fold_type;

   // Reciprocal factorial 1/idx! in Q60, each step truncated.
   function automatic logic [63:0] recip_fact(input int idx);
      logic [63:0] v;
      v = 64'd1 << WORK_FRAC;
      for (int n = 1; n <= idx; n++) begin
         v = v / 64'(n);
      end
      return v;
   endfunction

endpackage

### hw/rtl/scs_if.sv
// Valid/ready channel interfaces for angle requests and sine/cosine responses.
interface scs_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] angle;
   modport source (output valid, output angle, input ready);
   modport sink   (input valid, input angle, output ready);
endinterface

interface scs_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] sine;
   logic signed [31:0] cosine;
   modport source (output valid, output sine, output cosine, input ready);
   modport sink   (input valid, input sine, input cosine, output ready);
endinterface

### hw/rtl/scs_mac_cell.sv
// Two-stage fixed-point multiply-add cell: result = c + a*b truncated to Q60.
module scs_mac_cell #(
   parameter int SIDE_WIDTH = 1
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  logic                    in_valid,
   input  logic signed [63:0]      a,
   input  logic signed [63:0]      b,
   input  logic signed [63:0]      c,
   input  logic [SIDE_WIDTH-1:0]   side_in,
   output logic                    out_valid,
   output logic signed [63:0]      result,
   output logic [SIDE_WIDTH-1:0]   side_out
);

   logic [63:0] mag_a, mag_b;
   logic        v1_ff, neg_ff;
   logic [63:0] ll_ff, lh_ff, hl_ff, hh_ff;
   logic signed [63:0] c_ff;
   logic [SIDE_WIDTH-1:0] side1_ff;
   logic [127:0] full;
   logic signed [63:0] prod;
   logic        v2_ff;
   logic signed [63:0] res_ff;
   logic [SIDE_WIDTH-1:0] side2_ff;

   assign mag_a = a[63] ? 64'(-a) : 64'(a);
   assign mag_b = b[63] ? 64'(-b) : 64'(b);

   // Four 32x32 partial products are registered before they are summed.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
      end
      if (en) begin
         neg_ff   <= a[63] ^ b[63];
         ll_ff    <= 64'(mag_a[31:0])  * 64'(mag_b[31:0]);
         lh_ff    <= 64'(mag_a[31:0])  * 64'(mag_b[63:32]);
         hl_ff    <= 64'(mag_a[63:32]) * 64'(mag_b[31:0]);
         hh_ff    <= 64'(mag_a[63:32]) * 64'(mag_b[63:32]);
         c_ff     <= c;
         side1_ff <= side_in;
      end
   end

   always_comb begin
      full = {64'd0, ll_ff} + ({64'd0, lh_ff} << 32) + ({64'd0, hl_ff} << 32)
           + {hh_ff, 64'd0};
      prod = $signed({1'b0, full[122:60]});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= v1_ff;
      end
      if (en) begin
         res_ff   <= c_ff + (neg_ff ? -prod : prod);
         side2_ff <= side1_ff;
      end
   end

   assign out_valid = v2_ff;
   assign result    = res_ff;
   assign side_out  = side2_ff;

endmodule

### hw/rtl/sine_cosine_series.sv
// Throughput: one angle word per cycle while result words are accepted; the multiply-add cell chain is fully pipelined.
// The whole pipeline advances together and holds while a result word waits unaccepted.
// Reset (synchronous, active high) clears every valid bit; payload registers are not reset.
// The block keeps no state between words.
module sine_cosine_series
   import scs_pkg::*;
#(
   parameter int TERMS           = DEF_TERMS,
   parameter int ANGLE_FRAC_BITS = DEF_ANGLE_FRAC_BITS,
   parameter int OUT_FRAC_BITS   = DEF_OUT_FRAC_BITS
) (
   input logic         clock,
   input logic         reset,
   scs_req_if.sink     req_ch,
   scs_rsp_if.source   rsp_ch
);

   // Number of compare-subtract stages for the modulo 2*pi reduction. The scaled
   // angle magnitude is at most 2^62 and 2*pi exceeds 2^(ANGLE_FRAC_BITS+33), so the
   // quotient fits in this many bits.
   localparam int QB = 29 - ANGLE_FRAC_BITS;
   localparam int XSHIFT = WORK_FRAC - 31 - ANGLE_FRAC_BITS;
   localparam int RSHIFT = WORK_FRAC - OUT_FRAC_BITS;
   localparam logic signed [63:0] TWO_PI  = $signed(TWO_PI_Q59 >> (28 - ANGLE_FRAC_BITS));
   localparam logic signed [63:0] PI      = $signed(PI_Q59 >> (28 - ANGLE_FRAC_BITS));
   localparam logic signed [63:0] HALF_PI = $signed(HALF_PI_Q59 >> (28 - ANGLE_FRAC_BITS));
   localparam int FW = $bits(fold_type);

   // The pipeline moves whenever the output register is empty or being drained.
   logic en;
   assign en = !rsp_ch.valid || rsp_ch.ready;
   assign req_ch.ready = en;

   // Input stage: sign and magnitude of the angle, scaled up by 2^31.
   logic        red_v_ff   [0:QB];
   logic        red_neg_ff [0:QB];
   logic [63:0] red_mag_ff [0:QB];
   logic [31:0] abs_angle;

   assign abs_angle = req_ch.angle[31] ? 32'(-req_ch.angle) : 32'(req_ch.angle);

   always_ff @(posedge clock) begin
      if (reset) begin
         red_v_ff[0] <= 1'b0;
      end else if (en) begin
         red_v_ff[0] <= req_ch.valid;
      end
      if (en) begin
         red_neg_ff[0] <= req_ch.angle[31];
         red_mag_ff[0] <= {1'b0, abs_angle, 31'd0};
      end
   end

   // Restoring reduction: each stage removes one power-of-two multiple of 2*pi.
   // The remainder keeps the sign of the dividend.
   for (genvar i = 0; i < QB; i++) begin : g_reduce
      localparam logic [63:0] SUB = 64'(TWO_PI) << (QB - 1 - i);
      always_ff @(posedge clock) begin
         if (reset) begin
            red_v_ff[i+1] <= 1'b0;
         end else if (en) begin
            red_v_ff[i+1] <= red_v_ff[i];
         end
         if (en) begin
            red_neg_ff[i+1] <= red_neg_ff[i];
            red_mag_ff[i+1] <= (red_mag_ff[i] >= SUB) ? red_mag_ff[i] - SUB : red_mag_ff[i];
         end
      end
   end

   // Wrap into -pi..pi.
   logic               w_v_ff;
   logic signed [63:0] w_r_ff;
   logic signed [63:0] rem, wrapped;

   always_comb begin
      rem = red_neg_ff[QB] ? -$signed(red_mag_ff[QB]) : $signed(red_mag_ff[QB]);
      if (rem > PI) begin
         wrapped = rem - TWO_PI;
      end else if (rem < -PI) begin
         wrapped = rem + TWO_PI;
      end else begin
         wrapped = rem;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w_v_ff <= 1'b0;
      end else if (en) begin
         w_v_ff <= red_v_ff[QB];
      end
      if (en) begin
         w_r_ff <= wrapped;
      end
   end

   // Quarter-turn fold into -pi/2..pi/2, then move the angle to Q60.
   logic               f_v_ff;
   logic signed [63:0] f_x_ff;
   fold_type           f_fold_ff;
   logic signed [63:0] folded;
   fold_type           fold_code;

   always_comb begin
      if (w_r_ff > HALF_PI) begin
         folded    = w_r_ff - HALF_PI;
         fold_code = FOLD_POS;
      end else if (w_r_ff < -HALF_PI) begin
         folded    = w_r_ff + HALF_PI;
         fold_code = FOLD_NEG;
      end else begin
         folded    = w_r_ff;
         fold_code = FOLD_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_v_ff <= 1'b0;
      end else if (en) begin
         f_v_ff <= w_v_ff;
      end
      if (en) begin
         f_x_ff    <= folded <<< XSHIFT;
         f_fold_ff <= fold_code;
      end
   end

   // Square of the angle, which both series step through.
   logic               hv   [0:TERMS+1];
   logic signed [63:0] hu   [0:TERMS+1];
   logic signed [63:0] hx   [0:TERMS+1];
   logic [FW-1:0]      hf   [0:TERMS+1];
   logic signed [63:0] ps   [0:TERMS+1];
   logic signed [63:0] pc   [0:TERMS+1];
   logic [63+FW:0]     sq_side;

   scs_mac_cell #(.SIDE_WIDTH(64 + FW)) u_square (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (f_v_ff),
      .a        (f_x_ff),
      .b        (f_x_ff),
      .c        (64'sd0),
      .side_in  ({f_x_ff, f_fold_ff}),
      .out_valid(hv[0]),
      .result   (hu[0]),
      .side_out (sq_side)
   );

   assign hx[0] = $signed(sq_side[63+FW:FW]);
   assign hf[0] = sq_side[FW-1:0];
   assign ps[0] = 64'sd0;
   assign pc[0] = 64'sd0;

   // Horner chain: each cell pair folds in one term of the sine and cosine series,
   // highest order first, with alternating signs.
   for (genvar j = 0; j <= TERMS; j++) begin : g_horner
      localparam int K = TERMS - j;
      localparam logic signed [63:0] SIN_C = (K % 2 == 1) ? -$signed(recip_fact(2 * K + 1))
                                                          :  $signed(recip_fact(2 * K + 1));
      localparam logic signed [63:0] COS_C = (K % 2 == 1) ? -$signed(recip_fact(2 * K))
                                                          :  $signed(recip_fact(2 * K));
      logic          sv, cv;
      logic [127:0]  s_side;

      scs_mac_cell #(.SIDE_WIDTH(128)) u_sin (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .in_valid (hv[j]),
         .a        (hu[j]),
         .b        (ps[j]),
         .c        (SIN_C),
         .side_in  ({hu[j], hx[j]}),
         .out_valid(sv),
         .result   (ps[j+1]),
         .side_out (s_side)
      );

      scs_mac_cell #(.SIDE_WIDTH(FW)) u_cos (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .in_valid (hv[j]),
         .a        (hu[j]),
         .b        (pc[j]),
         .c        (COS_C),
         .side_in  (hf[j]),
         .out_valid(cv),
         .result   (pc[j+1]),
         .side_out (hf[j+1])
      );

      assign hv[j+1] = sv && cv;
      assign hu[j+1] = $signed(s_side[127:64]);
      assign hx[j+1] = $signed(s_side[63:0]);
   end

   // The odd series is finished by one more multiply with the angle itself.
   logic               e_v;
   logic signed [63:0] e_s;
   logic [63+FW:0]     e_side;
   logic signed [63:0] e_c;
   fold_type           e_fold;

   scs_mac_cell #(.SIDE_WIDTH(64 + FW)) u_sin_final (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (hv[TERMS+1]),
      .a        (hx[TERMS+1]),
      .b        (ps[TERMS+1]),
      .c        (64'sd0),
      .side_in  ({pc[TERMS+1], hf[TERMS+1]}),
      .out_valid(e_v),
      .result   (e_s),
      .side_out (e_side)
   );

   assign e_c    = $signed(e_side[63+FW:FW]);
   assign e_fold = fold_type'(e_side[FW-1:0]);

   // Round Q60 to the output format, half away from zero, and clamp to one.
   function automatic logic [31:0] to_out(input logic signed [63:0] v);
      logic [63:0] mag;
      logic [63:0] lim;
      mag = v[63] ? 64'(-v) : 64'(v);
      lim = 64'd1 << OUT_FRAC_BITS;
      mag = (mag + (64'd1 << (RSHIFT - 1))) >> RSHIFT;
      if (mag > lim) begin
         mag = lim;
      end
      return v[63] ? 32'(-mag) : mag[31:0];
   endfunction

   // Undo the quarter-turn fold by swapping the two results and negating one of them.
   logic signed [63:0] sel_s, sel_c;

   always_comb begin
      case (e_fold)
         FOLD_POS: begin
            sel_s = e_c;
            sel_c = -e_s;
         end
         FOLD_NEG: begin
            sel_s = -e_c;
            sel_c = e_s;
         end
         default: begin
            sel_s = e_s;
            sel_c = e_c;
         end
      endcase
   end

   // Output register: the result word is held here until the sink takes it.
   logic        out_v_ff;
   logic [31:0] out_s_ff, out_c_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (en) begin
         out_v_ff <= e_v;
      end
      if (en) begin
         out_s_ff <= to_out(sel_s);
         out_c_ff <= to_out(sel_c);
      end
   end

   assign rsp_ch.valid  = out_v_ff;
   assign rsp_ch.sine   = $signed(out_s_ff);
   assign rsp_ch.cosine = $signed(out_c_ff);

endmodule
